// ===== rtl/lav_pkg.sv =====
// Shared types and constants for the look-at view matrix block.
`default_nettype none

package lav_pkg;

    localparam int DATA_W      = 32;
    localparam int ROWS        = 4;
    localparam int NORM_MSB    = 29;
    localparam int SQRT_STEPS  = 32;
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 136;

    localparam logic [1:0] ROW_LAST = 2'd3;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic valid;
        logic zero;
    } unit_stat_t;

endpackage

`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix: input item in, four matrix rows out.
//
// Input channel s_*: one item holds eye and target points, signed Q16.16
// (FRAC_BITS fraction bits). Output channel m_*: four items per input,
// rows 0 to 3 in order, m_tlast on row 3, m_tuser set on all rows when a
// vector had zero length and the identity matrix is sent instead.
// Rows 0 to 3 leave one per cycle while m_tready is high. The output row
// serializer sends four rows per item and so limits the input rate; it
// loads the next item as the last row is taken. The pipeline itself takes
// an item every cycle while it is not frozen and holds several items in
// flight: two normalizer levels in series, the first with two side by side,
// each normalizer with a 32-stage square root and a FRAC_BITS+1 stage divider.
// Reset clears all valid bits; no results are pending afterwards.
// When the receiver stalls, the current row is held and the whole pipeline
// freezes once its last stage is full; s_tready then drops.
`default_nettype none

module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_index, col_zero, col_one, col_two, col_three, zero pad
    output logic [135:0] m_tdata,
    output logic         m_tlast,
    // degenerate
    output logic         m_tuser
);

    localparam int DW  = lav_pkg::DATA_W;
    localparam int OW  = FRAC_BITS + 2;
    localparam int CW  = DW + 2;
    localparam int PB  = 2 * OW;
    localparam int UW  = PB + 1;
    localparam int DPW = OW + DW;
    localparam int EW  = DPW + 2;
    localparam int EW1 = EW + 1;
    localparam int SW3 = 3 * DW + 6 * OW + 1;

    logic en;

    function automatic logic [DW-1:0] sx(input logic [OW-1:0] v);
        sx = {{(DW - OW){v[OW-1]}}, v};
    endfunction

    // stage A: differences
    logic               va_reg;
    logic [2:0][CW-1:0] da_reg;
    logic [2:0][CW-1:0] ra_reg;
    logic [3*DW-1:0]    eyea_reg;
    logic signed [DW:0] dd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dd[i] = $signed({s_tdata[96+DW*i+DW-1], s_tdata[96+DW*i +: DW]})
                  - $signed({s_tdata[DW*i+DW-1], s_tdata[DW*i +: DW]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                da_reg[i] <= CW'(dd[i]);
            end
            ra_reg[0] <= CW'(-CW'(dd[2]));
            ra_reg[1] <= '0;
            ra_reg[2] <= CW'(dd[0]);
            eyea_reg  <= s_tdata[3*DW-1:0];
        end
    end

    lav_pkg::unit_stat_t st1, st2, st3;
    logic [2:0][OW-1:0]  f, r, u;
    logic [2*DW-1:0]     side1;
    logic [DW-1:0]       side2;
    logic [SW3-1:0]      side3;

    lav_unit #(.FRAC_BITS(FRAC_BITS), .CW(CW), .SW(2 * DW)) u_dir (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(va_reg),
        .c(da_reg), .in_side(eyea_reg[2*DW-1:0]),
        .stat(st1), .n(f), .out_side(side1)
    );

    lav_unit #(.FRAC_BITS(FRAC_BITS), .CW(CW), .SW(DW)) u_right (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(va_reg),
        .c(ra_reg), .in_side(eyea_reg[3*DW-1:2*DW]),
        .stat(st2), .n(r), .out_side(side2)
    );

    // stage B: cross products
    logic                   vb_reg;
    logic signed [PB-1:0]   pb_reg [6];
    logic [2:0][OW-1:0]     rb_reg, fb_reg;
    logic [3*DW-1:0]        eyeb_reg;
    logic                   degb_reg;

    // stage C: differences of products
    logic                   vc_reg;
    logic [2:0][UW-1:0]     uc_reg;
    logic [2:0][OW-1:0]     rc_reg, fc_reg;
    logic [3*DW-1:0]        eyec_reg;
    logic                   degc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= st1.valid & st2.valid;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pb_reg[0] <= $signed(r[1]) * $signed(f[2]);
            pb_reg[1] <= $signed(f[1]) * $signed(r[2]);
            pb_reg[2] <= $signed(r[2]) * $signed(f[0]);
            pb_reg[3] <= $signed(f[2]) * $signed(r[0]);
            pb_reg[4] <= $signed(r[0]) * $signed(f[1]);
            pb_reg[5] <= $signed(f[0]) * $signed(r[1]);
            rb_reg    <= r;
            fb_reg    <= f;
            eyeb_reg  <= {side2, side1};
            degb_reg  <= st1.zero | st2.zero;
            uc_reg[0] <= UW'(pb_reg[0]) - UW'(pb_reg[1]);
            uc_reg[1] <= UW'(pb_reg[2]) - UW'(pb_reg[3]);
            uc_reg[2] <= UW'(pb_reg[4]) - UW'(pb_reg[5]);
            rc_reg    <= rb_reg;
            fc_reg    <= fb_reg;
            eyec_reg  <= eyeb_reg;
            degc_reg  <= degb_reg;
        end
    end

    lav_unit #(.FRAC_BITS(FRAC_BITS), .CW(UW), .SW(SW3)) u_up (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vc_reg),
        .c(uc_reg), .in_side({degc_reg, fc_reg, rc_reg, eyec_reg}),
        .stat(st3), .n(u), .out_side(side3)
    );

    logic [2:0][OW-1:0] r3, f3;
    logic [2:0][DW-1:0] eye3;
    logic               deg3;

    assign {deg3, f3, r3, eye3} = side3;

    // stage D: translation products
    logic                  vd_reg;
    logic signed [DPW-1:0] prd_reg [3][3];
    logic [2:0][OW-1:0]    rd_reg, ud_reg, fd_reg;
    logic                  degd_reg;

    // stage E: dot sums
    logic                  ve_reg;
    logic signed [EW-1:0]  se_reg [3];
    logic [2:0][OW-1:0]    re_reg, ue_reg, fe_reg;
    logic                  dege_reg;

    // stage F: finished matrix
    logic                  pv_reg;
    logic [DW-1:0]         matf_reg [4][4];
    logic                  degf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= st3.valid;
            ve_reg <= vd_reg;
            pv_reg <= ve_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prd_reg[0][i] <= $signed(r3[i]) * $signed(eye3[i]);
                prd_reg[1][i] <= $signed(u[i]) * $signed(eye3[i]);
                prd_reg[2][i] <= $signed(f3[i]) * $signed(eye3[i]);
            end
            rd_reg   <= r3;
            ud_reg   <= u;
            fd_reg   <= f3;
            degd_reg <= deg3 | st3.zero;
            se_reg[0] <= -(EW'(prd_reg[0][0]) + EW'(prd_reg[0][1]) + EW'(prd_reg[0][2]));
            se_reg[1] <= -(EW'(prd_reg[1][0]) + EW'(prd_reg[1][1]) + EW'(prd_reg[1][2]));
            se_reg[2] <= EW'(prd_reg[2][0]) + EW'(prd_reg[2][1]) + EW'(prd_reg[2][2]);
            re_reg   <= rd_reg;
            ue_reg   <= ud_reg;
            fe_reg   <= fd_reg;
            dege_reg <= degd_reg;
        end
    end

    // round half away from zero, then saturate
    logic [DW-1:0] tr [3];
    logic [DW-1:0] mat_next [4][4];

    always_comb begin
        logic          ng;
        logic [EW1-1:0] mg;
        logic [EW1-1:0] q;
        for (int i = 0; i < 3; i++) begin
            ng = se_reg[i][EW-1];
            mg = ng ? EW1'(-EW1'(se_reg[i])) : EW1'(se_reg[i]);
            q  = (mg + (EW1'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (!ng && q > EW1'(lav_pkg::SAT_POS)) begin
                tr[i] = lav_pkg::SAT_POS;
            end else if (ng && q > EW1'(lav_pkg::SAT_NEG)) begin
                tr[i] = lav_pkg::SAT_NEG;
            end else begin
                tr[i] = ng ? DW'(-q[DW-1:0]) : q[DW-1:0];
            end
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                mat_next[i][j] = (i == j) ? (DW'(1) << FRAC_BITS) : '0;
            end
        end
        if (!dege_reg) begin
            for (int j = 0; j < 3; j++) begin
                mat_next[0][j] = sx(re_reg[j]);
                mat_next[1][j] = sx(ue_reg[j]);
                mat_next[2][j] = DW'(-sx(fe_reg[j]));
            end
            mat_next[0][3] = tr[0];
            mat_next[1][3] = tr[1];
            mat_next[2][3] = tr[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            matf_reg <= mat_next;
            degf_reg <= dege_reg;
        end
    end

    // row serializer
    logic          busy_reg;
    logic [1:0]    cnt_reg;
    logic [DW-1:0] mat_reg [4][4];
    logic          deg_reg;
    logic          load;

    assign load = pv_reg && (!busy_reg || (m_tready && cnt_reg == lav_pkg::ROW_LAST));
    assign en   = !pv_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg && m_tready) begin
            if (cnt_reg == lav_pkg::ROW_LAST) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mat_reg <= matf_reg;
            deg_reg <= degf_reg;
        end
    end

    assign s_tready = en;
    assign m_tvalid = busy_reg;
    assign m_tlast  = cnt_reg == lav_pkg::ROW_LAST;
    assign m_tuser  = deg_reg;
    assign m_tdata  = {6'd0, mat_reg[cnt_reg][3], mat_reg[cnt_reg][2],
                       mat_reg[cnt_reg][1], mat_reg[cnt_reg][0], cnt_reg};

endmodule

`default_nettype wire

// ===== rtl/lav_unit.sv =====
// Pipelined vector normalizer: magnitude alignment, integer square root, rounding divide.
`default_nettype none

module lav_unit #(
    parameter int FRAC_BITS = 16,
    parameter int CW        = 34,
    parameter int SW        = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [2:0][CW-1:0]         c,
    input  logic [SW-1:0]              in_side,
    output lav_pkg::unit_stat_t        stat,
    output logic [2:0][FRAC_BITS+1:0]  n,
    output logic [SW-1:0]              out_side
);

    localparam int SQ  = lav_pkg::SQRT_STEPS;
    localparam int L   = 5 + SQ + 2 + FRAC_BITS;
    localparam int PW  = $clog2(CW);
    localparam int NB  = lav_pkg::NORM_MSB + 1;
    localparam int QB  = FRAC_BITS + 1;
    localparam int NW  = NB + 1 + FRAC_BITS;
    localparam int RW  = NB + 3;
    localparam int RW1 = RW + 1;
    localparam int MW  = NB + 2;
    localparam int SQW = 2 * NB;
    localparam int VW  = 2 * SQ;
    localparam int OW  = FRAC_BITS + 2;
    localparam int XW  = CW + NB;

    // control delay line
    logic [L-1:0]  vld_reg;
    logic [L-1:0]  zro_reg;
    logic [2:0]    neg_reg [L];
    logic [SW-1:0] sd_reg  [L];

    logic [2:0]         neg0;
    logic [2:0][CW-1:0] abs0;
    logic               zero0;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg0[i] = c[i][CW-1];
            abs0[i] = neg0[i] ? CW'(-c[i]) : c[i];
        end
        zero0 = ~|(abs0[0] | abs0[1] | abs0[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[L-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zro_reg    <= {zro_reg[L-2:0], zero0};
            neg_reg[0] <= neg0;
            sd_reg[0]  <= in_side;
            for (int k = 1; k < L; k++) begin
                neg_reg[k] <= neg_reg[k-1];
                sd_reg[k]  <= sd_reg[k-1];
            end
        end
    end

    // alignment
    logic [2:0][CW-1:0] a0_reg;
    logic [2:0][CW-1:0] a1_reg;
    logic [PW-1:0]      p_reg;
    logic [CW-1:0]      or1;
    logic [PW-1:0]      p1;
    logic [2:0][NB-1:0] an2;
    logic [2:0][NB-1:0] an2_reg;
    logic [2:0][NB-1:0] an3_reg;
    logic [2:0][SQW-1:0] sq_reg;

    always_comb begin
        or1 = a0_reg[0] | a0_reg[1] | a0_reg[2];
        p1  = '0;
        for (int b = 0; b < CW; b++) begin
            if (or1[b]) begin
                p1 = PW'(b);
            end
        end
    end

    always_comb begin
        logic [XW-1:0] w;
        for (int i = 0; i < 3; i++) begin
            w = XW'(a1_reg[i]);
            if (p_reg >= PW'(NB - 1)) begin
                an2[i] = NB'(w >> (p_reg - PW'(NB - 1)));
            end else begin
                an2[i] = NB'(w << (PW'(NB - 1) - p_reg));
            end
        end
    end

    // square root
    logic [VW-1:0]      sv_reg  [SQ+1];
    logic [VW-1:0]      sr_reg  [SQ+1];
    logic [2:0][NB-1:0] anq_reg [SQ+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg     <= abs0;
            a1_reg     <= a0_reg;
            p_reg      <= p1;
            an2_reg    <= an2;
            an3_reg    <= an2_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= an2_reg[i] * an2_reg[i];
            end
            sv_reg[0]  <= VW'(sq_reg[0]) + VW'(sq_reg[1]) + VW'(sq_reg[2]);
            sr_reg[0]  <= '0;
            anq_reg[0] <= an3_reg;
        end
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * j);
        logic [VW-1:0] trial;
        assign trial = sr_reg[j] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sv_reg[j] >= trial) begin
                    sv_reg[j+1] <= sv_reg[j] - trial;
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + BIT;
                end else begin
                    sv_reg[j+1] <= sv_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
                anq_reg[j+1] <= anq_reg[j];
            end
        end
    end

    // rounding divide, one quotient bit per stage
    logic [2:0][RW-1:0] dr_reg [QB+1];
    logic [2:0][QB-1:0] dn_reg [QB+1];
    logic [2:0][QB-1:0] dq_reg [QB+1];
    logic [MW-1:0]      dm_reg [QB+1];
    logic [MW-1:0]      mag;
    logic [2:0][NW-1:0] num;

    always_comb begin
        mag = sr_reg[SQ][MW-1:0];
        for (int i = 0; i < 3; i++) begin
            num[i] = NW'({anq_reg[SQ][i], FRAC_BITS'(0)}) + NW'(mag >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= RW'(num[i] >> QB);
                dn_reg[0][i] <= num[i][QB-1:0];
            end
            dq_reg[0] <= '0;
            dm_reg[0] <= mag;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [2:0][RW1-1:0] t;
        logic [2:0]          ge;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t[i]  = {dr_reg[j][i], dn_reg[j][i][QB-1]};
                ge[i] = t[i] >= RW1'(dm_reg[j]);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    dr_reg[j+1][i] <= ge[i] ? RW'(t[i] - RW1'(dm_reg[j])) : RW'(t[i]);
                    dq_reg[j+1][i] <= {dq_reg[j][i][QB-2:0], ge[i]};
                    dn_reg[j+1][i] <= dn_reg[j][i] << 1;
                end
                dm_reg[j+1] <= dm_reg[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n[i] = neg_reg[L-1][i] ? OW'(-OW'(dq_reg[QB][i])) : OW'(dq_reg[QB][i]);
        end
        stat.valid = vld_reg[L-1];
        stat.zero  = zro_reg[L-1];
        out_side   = sd_reg[L-1];
    end

endmodule

`default_nettype wire

// ===== rtl/lav_check.sv =====
// Port-level checker for the look-at view matrix block, with its bind.
`default_nettype none

module lav_check #(
    parameter int FRAC_BITS = 16
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast,
    input logic         m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == (m_tdata[1:0] == lav_pkg::ROW_LAST))
        else $error("tlast does not match row 3");

    a_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1
            && m_tuser == $past(m_tuser))
        else $error("matrix rows not contiguous");

    a_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tdata[1:0] == 2'd0 |->
            m_tdata[33:2] == (32'd1 << FRAC_BITS) && m_tdata[129:34] == '0)
        else $error("degenerate row 0 is not identity");

endmodule

bind look_at_view_matrix lav_check #(.FRAC_BITS(FRAC_BITS)) u_lav_check (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);

`default_nettype wire

// ===== tb/tb_look_at_view_matrix.sv =====
// Testbench for look_at_view_matrix: predicts each view matrix row by row and checks the stream.
`timescale 1ns / 1ps

module tb_look_at_view_matrix;

    localparam int FB = 16;
    localparam int LAT = 2 * FB + 84;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] c0, c1, c2, c3;
        logic        last;
        logic        deg;
    } row_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    row_t   rows_due[$];
    int     n_err = 0;
    int     idle_cycles = 0;
    bit     rx_hold = 0;
    bit     rx_enable = 0;

    look_at_view_matrix #(.FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic bit unit_vec(input longint c[3], output longint n[3]);
        logic [63:0] a[3], m, s, mg, q;
        bit ng[3];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            ng[i] = c[i] < 0;
            a[i] = ng[i] ? -c[i] : c[i];
            if (a[i] > m) m = a[i];
        end
        for (int i = 0; i < 3; i++) n[i] = 0;
        if (m == 0) return 0;
        while (m >= 64'd1 << 30) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        while (m < 64'd1 << 29) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        mg = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << FB) + (mg >> 1)) / mg;
            n[i] = ng[i] ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic logic [31:0] trans_round(longint s);
        logic [63:0] mg, q;
        longint v;
        mg = s < 0 ? -s : s;
        q = (mg + (64'd1 << (FB - 1))) >> FB;
        v = s < 0 ? -longint'(q) : longint'(q);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_view(logic [191:0] d);
        longint eye[3], tg[3], dv[3], rr[3], f[3], r[3], u[3], uc[3];
        longint mx[4][4];
        bit deg;
        row_t e;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(d[32*i +: 32]));
            tg[i] = longint'($signed(d[32*(i+3) +: 32]));
            dv[i] = tg[i] - eye[i];
        end
        rr[0] = -dv[2]; rr[1] = 0; rr[2] = dv[0];
        deg = 0;
        if (!unit_vec(dv, f) || !unit_vec(rr, r)) begin
            deg = 1;
        end else begin
            uc[0] = r[1] * f[2] - f[1] * r[2];
            uc[1] = r[2] * f[0] - f[2] * r[0];
            uc[2] = r[0] * f[1] - f[0] * r[1];
            if (!unit_vec(uc, u)) deg = 1;
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                mx[i][j] = (i == j) ? (64'sd1 << FB) : 0;
        if (!deg) begin
            for (int j = 0; j < 3; j++) begin
                mx[0][j] = r[j]; mx[1][j] = u[j]; mx[2][j] = -f[j];
            end
            mx[0][3] = $signed(trans_round(-(r[0]*eye[0] + r[1]*eye[1] + r[2]*eye[2])));
            mx[1][3] = $signed(trans_round(-(u[0]*eye[0] + u[1]*eye[1] + u[2]*eye[2])));
            mx[2][3] = $signed(trans_round(f[0]*eye[0] + f[1]*eye[1] + f[2]*eye[2]));
        end
        for (int i = 0; i < 4; i++) begin
            e.row = 2'(i);
            e.c0 = mx[i][0][31:0]; e.c1 = mx[i][1][31:0];
            e.c2 = mx[i][2][31:0]; e.c3 = mx[i][3][31:0];
            e.last = (i == 3);
            e.deg = deg;
            rows_due.push_back(e);
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_point(logic [191:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_view(d);
    endtask

    function automatic logic [191:0] pack_pts(logic [31:0] ex, ey, ez, tx, ty, tz);
        return {tz, ty, tx, ez, ey, ex};
    endfunction

    function automatic logic [31:0] rnd_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        if (p < 7) return $urandom_range(0, 2000) - 1000;
        if (p < 8) return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 0;
        while (rows_due.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
    endtask

    // receiver
    always @(posedge aclk) begin
        row_t got, e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.row = m_tdata[1:0];
                got.c0 = m_tdata[33:2];
                got.c1 = m_tdata[65:34];
                got.c2 = m_tdata[97:66];
                got.c3 = m_tdata[129:98];
                got.last = m_tlast;
                got.deg = m_tuser;
                if (rows_due.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected row %p", got);
                end else begin
                    e = rows_due.pop_front();
                    if (got !== e) begin
                        n_err++;
                        if (n_err <= 10) $display("mismatch exp %p got %p", e, got);
                    end
                end
            end
            if (!rx_enable || rx_hold) m_tready <= 0;
            else m_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
        send_point(pack_pts(0, 0, 0, 0, 0, 0));
        send_point(pack_pts(0, 0, 0, 0, 0, -32'sh10000));
        send_point(pack_pts(0, 0, 0, 0, 32'h10000, 0));
        send_point(pack_pts(5, 7, 9, 5, -300, 9));
        send_point(pack_pts(mx, mx, mx, mn, mn, mn));
        send_point(pack_pts(mn, mn, mn, mx, mx, mx));
        send_point(pack_pts(mx, 0, mn, mn, mx, mx));
        send_point(pack_pts(mn, mx, mx, mx, mn, mn));
        send_point(pack_pts(32'h10000, 0, 0, 0, 0, 0));
        send_point(pack_pts(0, 0, 0, 1, 0, 0));
        send_point(pack_pts(0, 0, 0, 0, 1, 1));
        send_point(pack_pts(1, 2, 3, 1, 2, 4));
        send_point(pack_pts(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 0));
        send_point(pack_pts(mx, mx, mx, mx, mx, mx - 1));
        send_point(pack_pts(mn, mn, mn, mn + 1, mn, mn));
        send_point(pack_pts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send_point(pack_pts(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        send_point(pack_pts(0, 0, 32'h0100_0000, 0, 0, 0));
    endtask

    task automatic test_random(int n);
        logic [31:0] ex, ey, ez, tx, ty, tz;
        for (int i = 0; i < n; i++) begin
            ex = rnd_coord(); ey = rnd_coord(); ez = rnd_coord();
            tx = rnd_coord(); ty = rnd_coord(); tz = rnd_coord();
            if ($urandom_range(0, 19) == 0) begin
                tx = ex; tz = ez;
            end else if ($urandom_range(0, 9) == 0) begin
                tx = ex + $urandom_range(0, 2) - 1;
                tz = ez + $urandom_range(0, 2) - 1;
            end
            send_point(pack_pts(ex, ey, ez, tx, ty, tz));
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (600) @(posedge aclk);
                rx_hold = 0;
            end
            test_random(40);
        join
    endtask

    task automatic test_pause();
        test_random(10);
        wait_drained();
        test_random(10);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        rx_enable = 1;
        test_directed();
        test_backpressure();
        test_pause();
        test_random(390);
        wait_drained();
        if (n_err == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
